// ===== sv/i2c_slave_speed_link_unit_macros.svh =====
// Assertion macros shared by the speed link RTL.
`ifndef I2C_SLAVE_SPEED_LINK_UNIT_MACROS_SVH
`define I2C_SLAVE_SPEED_LINK_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ISL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ISL_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/isl_pkg.sv =====
// Shared types and constants of the speed link block.
`default_nettype none

package isl_pkg;

  localparam int unsigned SUM_BITS_DEFAULT = 16;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned DIVISOR_BITS     = 16;

  localparam logic [7:0] SCALE_RESET = 8'd1;
  localparam logic [6:0] MAG_MAX     = 7'b1111111;
  localparam logic [7:0] SIGN_BIT    = 8'b10000000;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_SPEED,
    OP_OVERFLOW,
    OP_TX
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] rx_byte;
    logic [7:0] count;
  } cmd_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        speed_valid;
    logic [15:0] speed_command;
    logic        overflow_seen;
    logic        divide_error;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/isl_queue.sv =====
// Small register queue between the front and back parts.
`default_nettype none
`include "i2c_slave_speed_link_unit_macros.svh"

module isl_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ISL_ASSERT(a_no_push_when_full, push_i |-> !full_o, "push while queue full")
  `ISL_ASSERT(a_no_pop_when_empty, pop_i |-> !empty_o, "pop while queue empty")
  `ISL_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "queue count beyond depth")

endmodule

`default_nettype wire

// ===== sv/isl_front.sv =====
// Front part: tracks the link mode and classifies each bus event.
`default_nettype none
`include "i2c_slave_speed_link_unit_macros.svh"

module isl_front import isl_pkg::*; #(
  parameter int unsigned SumBits = SUM_BITS_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic               q_full_i,
  input  wire logic               is_read_i,
  input  wire logic               is_data_i,
  input  wire logic               rx_overflow_i,
  input  wire logic               master_nack_i,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic [SumBits-1:0] speed_sum_i,
  input  wire logic [7:0]         sample_count_i,
  output logic                    q_push_o,
  output cmd_t                    q_cmd_o,
  output logic [SumBits-1:0]      q_sum_o
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_RECEIVE,
    MODE_TRANSMIT
  } mode_e;

  mode_e mode_q, mode_d;
  op_e   op;

  assign q_push_o = push_i && !q_full_i;

  always_comb begin
    mode_d = mode_q;
    op     = OP_NONE;
    unique case (mode_q)
      MODE_TRANSMIT: begin
        if (!master_nack_i) begin
          op = OP_TX;
        end else begin
          mode_d = MODE_IDLE;
        end
      end
      default: begin
        if (!is_read_i) begin
          mode_d = MODE_RECEIVE;
          if (is_data_i) begin
            op = rx_overflow_i ? OP_OVERFLOW : OP_SPEED;
          end
        end else begin
          op     = OP_TX;
          mode_d = MODE_TRANSMIT;
        end
      end
    endcase
  end

  assign q_cmd_o = '{op: op, rx_byte: rx_byte_i, count: sample_count_i};
  assign q_sum_o = speed_sum_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else if (q_push_o) begin
      mode_q <= mode_d;
    end
  end

  `ISL_ASSERT(a_tx_enters_transmit, (q_push_o && q_cmd_o.op == OP_TX) |=> mode_q == MODE_TRANSMIT,
              "transmit event did not leave link in transmit mode")

endmodule

`default_nettype wire

// ===== sv/isl_back.sv =====
// Back part: decodes speed commands and averages the speed sum for transmit.
`default_nettype none
`include "i2c_slave_speed_link_unit_macros.svh"

module isl_back import isl_pkg::*; #(
  parameter int unsigned SumBits = SUM_BITS_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               q_empty_i,
  input  wire cmd_t               q_cmd_i,
  input  wire logic [SumBits-1:0] q_sum_i,
  output logic                    q_pop_o,
  input  wire logic               pop_i,
  output res_t                    res_o,
  output logic                    res_valid_o
);

  localparam int unsigned CntW = $clog2(SumBits);
  localparam int unsigned DivW = DIVISOR_BITS;

  typedef enum logic {
    B_IDLE,
    B_DIV
  } state_e;

  state_e            state_q, state_d;
  logic [7:0]        scale_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DivW-1:0]   divisor_q, divisor_d;
  logic [DivW-1:0]   rem_q, rem_d;
  logic [SumBits-1:0] dq_q, dq_d;
  logic              neg_q, neg_d;
  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;

  logic              take, div_zero, start_div, last_step, ge;
  logic [DivW:0]     trial;
  logic [SumBits-1:0] quot, sum_mag;
  logic [6:0]        mag;
  logic [14:0]       spd_mag;
  logic [15:0]       spd_ext;
  res_t              res_direct, res_div;

  assign take      = (state_q == B_IDLE) && !q_empty_i && (!out_valid_q || pop_i);
  assign q_pop_o   = take;
  assign div_zero  = (q_cmd_i.count == '0) || (scale_q == '0);
  assign start_div = take && (q_cmd_i.op == OP_TX) && !div_zero;
  assign last_step = (state_q == B_DIV) && (cnt_q == CntW'(SumBits - 1));

  // Speed command: sign-magnitude byte times scale.
  assign spd_mag = {8'b0, q_cmd_i.rx_byte[6:0]} * {7'b0, scale_q};
  assign spd_ext = {1'b0, spd_mag};
  assign sum_mag = q_sum_i[SumBits-1] ? (~q_sum_i + SumBits'(1)) : q_sum_i;

  always_comb begin
    res_direct = '0;
    case (q_cmd_i.op)
      OP_SPEED: begin
        res_direct.speed_valid   = 1'b1;
        res_direct.speed_command = (q_cmd_i.rx_byte & SIGN_BIT) != '0 ?
                                   (~spd_ext + 16'd1) : spd_ext;
      end
      OP_OVERFLOW: res_direct.overflow_seen = 1'b1;
      OP_TX: begin
        res_direct.tx_valid     = 1'b1;
        res_direct.divide_error = 1'b1;
      end
      default: res_direct = '0;
    endcase
  end

  // One restoring step per cycle: |sum| / (count * scale).
  assign trial = {rem_q, dq_q[SumBits-1]};
  assign ge    = trial >= {1'b0, divisor_q};
  assign quot  = {dq_q[SumBits-2:0], ge};
  assign mag   = (quot[SumBits-1:7] != '0) ? MAG_MAX : quot[6:0];

  always_comb begin
    res_div          = '0;
    res_div.tx_valid = 1'b1;
    res_div.tx_byte  = (neg_q && mag != '0) ? (SIGN_BIT | {1'b0, mag}) : {1'b0, mag};
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    divisor_d   = divisor_q;
    rem_d       = rem_q;
    dq_d        = dq_q;
    neg_d       = neg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop_i;
    unique case (state_q)
      B_IDLE: begin
        if (start_div) begin
          state_d   = B_DIV;
          cnt_d     = '0;
          divisor_d = {8'b0, q_cmd_i.count} * {8'b0, scale_q};
          rem_d     = '0;
          dq_d      = sum_mag;
          neg_d     = q_sum_i[SumBits-1];
        end else if (take) begin
          out_d       = res_direct;
          out_valid_d = 1'b1;
        end
      end
      B_DIV: begin
        rem_d = ge ? DivW'(trial - {1'b0, divisor_q}) : trial[DivW-1:0];
        dq_d  = quot;
        cnt_d = cnt_q + CntW'(1);
        if (last_step) begin
          state_d     = B_IDLE;
          out_d       = res_div;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      scale_q     <= SCALE_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        scale_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    dq_q      <= dq_d;
    neg_q     <= neg_d;
    out_q     <= out_d;
  end

  assign res_o       = out_q;
  assign res_valid_o = out_valid_q;

  `ISL_ASSERT(a_div_result_slot_free, last_step |-> (!out_valid_q || pop_i),
              "division finished while result register still held")
  `ISL_ASSERT(a_no_tx_no_byte, (out_valid_q && !out_q.tx_valid) |-> out_q.tx_byte == '0,
              "transmit byte set without transmit")

endmodule

`default_nettype wire

// ===== sv/i2c_slave_speed_link_unit.sv =====
// Top level of the I2C slave speed link: front classifier, queue, back executor.
//
//   channel  direction  handshake              payload
//   event    in         push / full            is_read .. sample_count
//   result   out        empty / pop            tx_valid .. divide_error
//   config   in         cfg_valid / cfg_ready  speed_scale (8 bit)
//
// An event is taken in the cycle it is pushed while the queue has room.
// The back part answers address, speed and overflow events, and a transmit with
// zero count or scale, directly; other transmits use the one-bit-per-cycle divider.
// Reset leaves the link idle, the queue and result register empty, scale at 1.
// A stalled result port holds the result register; the queue then fills.
`default_nettype none

module i2c_slave_speed_link_unit import isl_pkg::*; #(
  parameter int unsigned SumBits = SUM_BITS_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               is_read_i,
  input  wire logic               is_data_i,
  input  wire logic               rx_overflow_i,
  input  wire logic               master_nack_i,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic [SumBits-1:0] speed_sum_i,
  input  wire logic [7:0]         sample_count_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    tx_valid_o,
  output logic [7:0]              tx_byte_o,
  output logic                    speed_valid_o,
  output logic signed [15:0]      speed_command_o,
  output logic                    overflow_seen_o,
  output logic                    divide_error_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_data_i
);

  localparam int unsigned QW = $bits(cmd_t) + SumBits;

  logic               q_push, q_full, q_pop, q_empty, res_valid;
  cmd_t               f_cmd, b_cmd;
  logic [SumBits-1:0] f_sum, b_sum;
  logic [QW-1:0]      q_wdata, q_rdata;
  res_t               res;

  assign cfg_ready_o = 1'b1;

  isl_front #(.SumBits(SumBits)) u_front (
    .clk_i,
    .rst_ni,
    .push_i         (push),
    .q_full_i       (q_full),
    .is_read_i,
    .is_data_i,
    .rx_overflow_i,
    .master_nack_i,
    .rx_byte_i,
    .speed_sum_i,
    .sample_count_i,
    .q_push_o       (q_push),
    .q_cmd_o        (f_cmd),
    .q_sum_o        (f_sum)
  );

  assign q_wdata = {f_cmd, f_sum};
  assign full    = q_full;

  isl_queue #(.Width(QW), .Depth(QUEUE_DEPTH)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  assign b_cmd = q_rdata[QW-1:SumBits];
  assign b_sum = q_rdata[SumBits-1:0];

  isl_back #(.SumBits(SumBits)) u_back (
    .clk_i,
    .rst_ni,
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i,
    .q_empty_i   (q_empty),
    .q_cmd_i     (b_cmd),
    .q_sum_i     (b_sum),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  assign empty           = !res_valid;
  assign tx_valid_o      = res.tx_valid;
  assign tx_byte_o       = res.tx_byte;
  assign speed_valid_o   = res.speed_valid;
  assign speed_command_o = res.speed_command;
  assign overflow_seen_o = res.overflow_seen;
  assign divide_error_o  = res.divide_error;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the I2C slave speed link unit.
module testbench import isl_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SUM_W          = SUM_BITS_DEFAULT;
  localparam int unsigned SETTLE_CYCLES  = SUM_W + 8;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASES         = 7;
  localparam int unsigned RAND_PER_PHASE = 248;
  localparam int unsigned CYCLE_LIMIT    = 600000;
  localparam int unsigned PRINT_LIMIT    = 40;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_RECEIVE,
    MODE_TRANSMIT
  } link_mode_e;

  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_RANDOM,
    POP_PATTERN
  } pop_mode_e;

  typedef struct {
    logic             is_read;
    logic             is_data;
    logic             rx_overflow;
    logic             master_nack;
    logic [7:0]       rx_byte;
    logic [SUM_W-1:0] speed_sum;
    logic [7:0]       sample_count;
  } link_ev_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             push           = 1'b0;
  logic             full;
  logic             is_read_i      = 1'b0;
  logic             is_data_i      = 1'b0;
  logic             rx_overflow_i  = 1'b0;
  logic             master_nack_i  = 1'b0;
  logic [7:0]       rx_byte_i      = '0;
  logic [SUM_W-1:0] speed_sum_i    = '0;
  logic [7:0]       sample_count_i = '0;
  logic             empty;
  logic             pop            = 1'b0;
  logic             tx_valid_o;
  logic [7:0]       tx_byte_o;
  logic             speed_valid_o;
  logic [15:0]      speed_command_o;
  logic             overflow_seen_o;
  logic             divide_error_o;
  logic             cfg_valid_i    = 1'b0;
  logic             cfg_ready_o;
  logic [7:0]       cfg_data_i     = '0;

  // predictor state
  link_mode_e link_mode    = MODE_IDLE;
  logic [7:0] last_rx_byte = '0;
  logic [7:0] speed_scale  = SCALE_RESET;

  link_ev_t   pending_events[$];
  res_t       expected_results[$];
  int         mismatch_count = 0;
  int         cycle_count    = 0;

  // idling controls, set per phase
  logic        sender_gaps = 1'b0;
  pop_mode_e   pop_mode    = POP_ALWAYS;
  logic [15:0] pop_mask    = 16'hffff;
  int          hold_token  = 0;

  i2c_slave_speed_link_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .is_read_i       (is_read_i),
    .is_data_i       (is_data_i),
    .rx_overflow_i   (rx_overflow_i),
    .master_nack_i   (master_nack_i),
    .rx_byte_i       (rx_byte_i),
    .speed_sum_i     (speed_sum_i),
    .sample_count_i  (sample_count_i),
    .empty           (empty),
    .pop             (pop),
    .tx_valid_o      (tx_valid_o),
    .tx_byte_o       (tx_byte_o),
    .speed_valid_o   (speed_valid_o),
    .speed_command_o (speed_command_o),
    .overflow_seen_o (overflow_seen_o),
    .divide_error_o  (divide_error_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Advance the link state by one bus event and return the result it produces.
  function automatic res_t predict_link(input link_ev_t ev);
    res_t        r;
    logic        do_tx;
    int          cmd;
    int          sum_v;
    int          cnt_v;
    int          avg;
    int unsigned mag;
    r     = '0;
    do_tx = 1'b0;
    if (link_mode == MODE_TRANSMIT) begin
      if (!ev.master_nack) do_tx = 1'b1;
      else link_mode = MODE_IDLE;
    end else if (!ev.is_read) begin
      last_rx_byte = ev.rx_byte;
      link_mode    = MODE_RECEIVE;
      if (ev.is_data) begin
        if (!ev.rx_overflow) begin
          cmd = int'(last_rx_byte & {1'b0, MAG_MAX}) * int'(speed_scale);
          if ((last_rx_byte & SIGN_BIT) != 0) cmd = -cmd;
          r.speed_valid   = 1'b1;
          r.speed_command = cmd[15:0];
        end else begin
          r.overflow_seen = 1'b1;
        end
      end
    end else begin
      do_tx     = 1'b1;
      link_mode = MODE_TRANSMIT;
    end
    if (do_tx) begin
      r.tx_valid = 1'b1;
      sum_v      = int'($signed(ev.speed_sum));
      cnt_v      = int'(ev.sample_count);
      if (cnt_v == 0 || speed_scale == 0) begin
        r.divide_error = 1'b1;
      end else begin
        // integer division truncates toward zero, as the hardware does
        avg = sum_v / cnt_v / int'(speed_scale);
        mag = (avg < 0) ? -avg : avg;
        if (mag > MAG_MAX) mag = MAG_MAX;
        r.tx_byte = (avg < 0 && mag != 0) ? (SIGN_BIT | 8'(mag)) : 8'(mag);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Sender: offer the oldest pending event, in bursts with gaps in between when sender gaps are on.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    link_ev_t ev;
    int       burst_left;
    int       gap_left;
    if (!rst_ni) begin
      push       <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(predict_link(pending_events[0]));
        void'(pending_events.pop_front());
      end
      if (push && full) begin
        // hold the offered event until the queue takes it
      end else if (gap_left != 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_events.size() != 0) begin
        ev             = pending_events[0];
        push           <= 1'b1;
        is_read_i      <= ev.is_read;
        is_data_i      <= ev.is_data;
        rx_overflow_i  <= ev.rx_overflow;
        master_nack_i  <= ev.master_nack;
        rx_byte_i      <= ev.rx_byte;
        speed_sum_i    <= ev.speed_sum;
        sample_count_i <= ev.sample_count;
        if (sender_gaps) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 10);
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(1, 8);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: stall on its own pattern; a long hold-off lets the block fill up.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    int hold_seen;
    int hold_left;
    int pat_idx;
    if (!rst_ni) begin
      pop       <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
      pat_idx   = 0;
    end else begin
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (pop_mode)
          POP_ALWAYS: pop <= 1'b1;
          POP_RANDOM: pop <= ($urandom_range(0, 3) != 0);
          default: begin
            pat_idx = (pat_idx + 1) % 16;
            pop     <= pop_mask[pat_idx];
          end
        endcase
      end
    end
  end

  // Compare each transfer on the result side with the oldest expectation.
  always @(posedge clk_i) begin : monitor
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", tx_byte_o, 0);
      end else begin
        want = expected_results.pop_front();
        check_field("tx_valid", tx_valid_o, want.tx_valid);
        check_field("tx_byte", tx_byte_o, want.tx_byte);
        check_field("speed_valid", speed_valid_o, want.speed_valid);
        check_field("speed_command", speed_command_o, want.speed_command);
        check_field("overflow_seen", overflow_seen_o, want.overflow_seen);
        check_field("divide_error", divide_error_o, want.divide_error);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [SUM_W-1:0] rand_sum();
    case ($urandom_range(0, 5))
      0:       return SUM_W'($urandom);
      1:       return $urandom_range(0, 1) ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      default: return SUM_W'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic logic [7:0] rand_count();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1, 2, 3: return 8'($urandom_range(1, 16));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic link_ev_t rand_event();
    link_ev_t ev;
    ev.is_read      = 1'($urandom);
    ev.is_data      = 1'($urandom);
    ev.rx_overflow  = 1'($urandom);
    ev.master_nack  = 1'($urandom);
    ev.rx_byte      = 8'($urandom);
    ev.speed_sum    = rand_sum();
    ev.sample_count = rand_count();
    return ev;
  endfunction

  function automatic link_ev_t make_event(input logic rd, input logic dat, input logic ovf,
                                          input logic nack, input logic [7:0] rx_b,
                                          input int sum_v, input int cnt_v);
    link_ev_t ev;
    ev.is_read      = rd;
    ev.is_data      = dat;
    ev.rx_overflow  = ovf;
    ev.master_nack  = nack;
    ev.rx_byte      = rx_b;
    ev.speed_sum    = SUM_W'(sum_v);
    ev.sample_count = 8'(cnt_v);
    return ev;
  endfunction

  // Address byte followed by a few data bytes, now and then with overflow.
  function automatic int queue_write_burst();
    link_ev_t ev;
    int       n;
    n              = $urandom_range(1, 4);
    ev             = rand_event();
    ev.is_read     = 1'b0;
    ev.is_data     = 1'b0;
    ev.master_nack = 1'b1;
    pending_events.push_back(ev);
    for (int i = 0; i < n; i++) begin
      ev             = rand_event();
      ev.is_read     = 1'b0;
      ev.is_data     = 1'b1;
      ev.rx_overflow = ($urandom_range(0, 7) == 0);
      ev.master_nack = 1'b1;
      pending_events.push_back(ev);
    end
    return n + 1;
  endfunction

  // Read request, a run of ACKed bytes, then the closing NACK.
  function automatic int queue_read_burst();
    link_ev_t ev;
    int       n;
    n          = $urandom_range(0, 4);
    ev         = rand_event();
    ev.is_read = 1'b1;
    pending_events.push_back(ev);
    for (int i = 0; i < n; i++) begin
      ev             = rand_event();
      ev.master_nack = 1'b0;
      pending_events.push_back(ev);
    end
    ev             = rand_event();
    ev.master_nack = 1'b1;
    pending_events.push_back(ev);
    return n + 2;
  endfunction

  task automatic queue_directed();
    // an address byte ignores overflow and decodes nothing
    pending_events.push_back(make_event(1'b0, 1'b0, 1'b1, 1'b0, 8'ha5, 0, 0));
    // zero, full positive, negative zero and full negative speed bytes
    pending_events.push_back(make_event(1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 0, 0));
    pending_events.push_back(make_event(1'b0, 1'b1, 1'b0, 1'b1, 8'h7f, 0, 0));
    pending_events.push_back(make_event(1'b0, 1'b1, 1'b0, 1'b0, 8'h80, 0, 0));
    pending_events.push_back(make_event(1'b0, 1'b1, 1'b0, 1'b0, 8'hff, 0, 0));
    // drop a data byte on overflow
    pending_events.push_back(make_event(1'b0, 1'b1, 1'b1, 1'b0, 8'h81, 0, 0));
    // read from receive mode: NACK outside transmit is ignored, average saturates
    pending_events.push_back(make_event(1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 32767, 1));
    pending_events.push_back(make_event(1'b0, 1'b1, 1'b1, 1'b0, 8'hff, -32768, 1));
    pending_events.push_back(make_event(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, -1, 2));
    pending_events.push_back(make_event(1'b0, 1'b0, 1'b0, 1'b0, 8'h12, 100, 3));
    pending_events.push_back(make_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h34, -100, 7));
    pending_events.push_back(make_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 500, 0));
    pending_events.push_back(make_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 0, 255));
    pending_events.push_back(make_event(1'b0, 1'b1, 1'b0, 1'b1, 8'h56, 0, 0));
    // read straight from idle
    pending_events.push_back(make_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, -255, 255));
    pending_events.push_back(make_event(1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 0, 0));
  endtask

  // Wait until every event is taken and every result has come back, then settle.
  task automatic drain_link();
    while (pending_events.size() != 0 || expected_results.size() != 0 || push)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_speed_scale(input logic [7:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    speed_scale = value;
  endtask

  initial begin : stimulus
    int   added;
    int   kind;
    logic hold_phase;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1:       write_speed_scale(8'd255);
        2:       write_speed_scale(8'd0);
        3:       write_speed_scale(8'd128);
        4:       write_speed_scale(8'($urandom_range(2, 254)));
        5:       write_speed_scale(8'd1);
        6:       write_speed_scale(8'($urandom_range(2, 254)));
        default: ;
      endcase
      hold_phase  = (phase == 2 || phase == 5);
      sender_gaps = (phase % 2 == 1) && !hold_phase;
      pop_mode    = pop_mode_e'(phase % 3);
      pop_mask    = 16'($urandom) | 16'h0001;
      if (hold_phase) hold_token++;
      if (phase == 0) queue_directed();
      added = 0;
      while (added < RAND_PER_PHASE) begin
        kind = $urandom_range(0, 19);
        if (kind < 9) added += queue_write_burst();
        else if (kind < 17) added += queue_read_burst();
        else begin
          pending_events.push_back(rand_event());
          added++;
        end
      end
      drain_link();
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
